// ===== rtl/lzwd_pkg.sv =====
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared types and constants of the variable-width LZW decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lzwd_pkg;

  // Literal codes occupy the bottom of the code space.
  localparam int unsigned Literals      = 256;
  localparam int unsigned StartWidth    = 9;
  localparam int unsigned DefMaxWidth   = 12;
  localparam int unsigned DefMaxString  = 64;
  // Stored string length, clamped to one past the longest legal string.
  localparam int unsigned LenW          = 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BITS,
    ST_LOOK,
    ST_SPELL,
    ST_EMIT_RD,
    ST_EMIT_OUT,
    ST_ERR_OUT
  } dec_state_e;

endpackage

`default_nettype wire

// ===== rtl/lzwd_if.sv =====
// ----------------------------------------------------------------------------
// lzwd interfaces
// Valid/ready channels for stream bytes, decoded bytes and the length register.
// ----------------------------------------------------------------------------
`default_nettype none

interface lzwd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface lzwd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       finished;
  logic       string_too_long;
  modport source (output valid, output out_byte, output last_of_run, output finished,
                  output string_too_long, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, input finished,
                  input string_too_long, output ready);
endinterface

interface lzwd_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] total_bytes;
  modport source (output valid, output total_bytes, input ready);
  modport sink   (input valid, input total_bytes, output ready);
endinterface

`default_nettype wire

// ===== rtl/lzwd_dict.sv =====
// ----------------------------------------------------------------------------
// lzwd_dict
// Dictionary memory: prefix, suffix, first byte and length per entry.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwd_dict #(
  parameter int unsigned MaxWidth = lzwd_pkg::DefMaxWidth
) (
  input  wire logic                      clk_i,
  input  wire logic                      wr_en_i,
  input  wire logic [MaxWidth-1:0]       wr_addr_i,
  input  wire logic [MaxWidth-1:0]       wr_prefix_i,
  input  wire logic [7:0]                wr_suffix_i,
  input  wire logic [7:0]                wr_first_i,
  input  wire logic [lzwd_pkg::LenW-1:0] wr_len_i,
  input  wire logic [MaxWidth-1:0]       rd_addr_i,
  output logic [MaxWidth-1:0]            rd_prefix_o,
  output logic [7:0]                     rd_suffix_o,
  output logic [7:0]                     rd_first_o,
  output logic [lzwd_pkg::LenW-1:0]      rd_len_o
);
  import lzwd_pkg::*;

  localparam int unsigned Depth = 1 << MaxWidth;

  logic [MaxWidth-1:0] prefix_mem [Depth];
  logic [7:0]          suffix_mem [Depth];
  logic [7:0]          first_mem  [Depth];
  logic [LenW-1:0]     len_mem    [Depth];

  // One write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      prefix_mem[wr_addr_i] <= wr_prefix_i;
      suffix_mem[wr_addr_i] <= wr_suffix_i;
      first_mem[wr_addr_i]  <= wr_first_i;
      len_mem[wr_addr_i]    <= wr_len_i;
    end
    rd_prefix_o <= prefix_mem[rd_addr_i];
    rd_suffix_o <= suffix_mem[rd_addr_i];
    rd_first_o  <= first_mem[rd_addr_i];
    rd_len_o    <= len_mem[rd_addr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/lzw_variable_width_decoder.sv =====
// ----------------------------------------------------------------------------
// lzw_variable_width_decoder
// Variable-width LZW decoder: packed codes in, decoded bytes out.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                          | handshake
//  in_i     | in  | in_byte                                          | valid/ready
//  out_o    | out | out_byte, last_of_run, finished, string_too_long | valid/ready
//  cfg_i    | in  | total_bytes                                      | valid/ready
//
//  A stream byte is accepted in ST_IDLE and shifted into the code gatherer bit by
//  bit. Each completed code then passes through a lookup, a walk of its prefix
//  chain with a closing walk step (the first code skips the walk), a stack read
//  and then an output step per decoded byte, and a step to resume. The chain walk
//  is bound by the dictionary memory read latency. One byte is worked at a time.
//  Reset clears all control state; dictionary and stack are written before read.
//  A stalled output holds the decoder in place.
// ----------------------------------------------------------------------------
`default_nettype none

module lzw_variable_width_decoder #(
  parameter int unsigned MaxWidth  = lzwd_pkg::DefMaxWidth,
  parameter int unsigned MaxString = lzwd_pkg::DefMaxString
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lzwd_in_if.sink     in_i,
  lzwd_out_if.source  out_o,
  lzwd_cfg_if.sink    cfg_i
);
  import lzwd_pkg::*;

  localparam int unsigned NeW = MaxWidth + 1;
  localparam int unsigned PW  = $clog2(MaxString + 1);
  localparam int unsigned AW  = $clog2(MaxString);
  localparam int unsigned CwW = 5;

  dec_state_e state_q, state_d;

  logic [31:0]         total_q, bytes_q, bytes_d;
  logic [7:0]          byte_q, byte_d;
  logic [3:0]          bits_q, bits_d;
  logic [MaxWidth-1:0] gather_q, gather_d;
  logic [CwW-1:0]      held_q, held_d, cw_q, cw_d;
  logic [NeW-1:0]      ne_q, ne_d;
  logic [MaxWidth-1:0] prev_q, prev_d, code_q, code_d, c_q, c_d;
  logic [LenW-1:0]     prev_len_q, prev_len_d;
  logic [7:0]          prev_first_q, prev_first_d;
  logic                first_seen_q, first_seen_d, halted_q, halted_d;
  logic [PW-1:0]       len_q, len_d, i_q, i_d, pos_q, pos_d;

  // Dictionary ports.
  logic                dict_we;
  logic [MaxWidth-1:0] dict_wa, dict_wp, dict_ra, rd_prefix;
  logic [7:0]          dict_ws, dict_wf, rd_suffix, rd_first;
  logic [LenW-1:0]     dict_wl, rd_len;

  // Spelling stack ports.
  logic         stk_we;
  logic [AW-1:0] stk_wa, stk_ra;
  logic [7:0]   stk_wd, stk_rd_q;
  logic [7:0]   stk_mem [MaxString];

  lzwd_dict #(.MaxWidth(MaxWidth)) u_dict (
    .clk_i       (clk_i),
    .wr_en_i     (dict_we),
    .wr_addr_i   (dict_wa),
    .wr_prefix_i (dict_wp),
    .wr_suffix_i (dict_ws),
    .wr_first_i  (dict_wf),
    .wr_len_i    (dict_wl),
    .rd_addr_i   (dict_ra),
    .rd_prefix_o (rd_prefix),
    .rd_suffix_o (rd_suffix),
    .rd_first_o  (rd_first),
    .rd_len_o    (rd_len)
  );

  // Stack memory for one string, spelled back to front.
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    stk_rd_q <= stk_mem[stk_ra];
  end

  // Helper values for the code lookup.
  logic                code_lit, known, table_open, stop;
  logic [LenW-1:0]     clen, plen, plen_clamp, len_full;
  logic [7:0]          cfirst;
  logic [NeW-1:0]      ne_new, grow_at;
  logic [32:0]         bytes_inc;
  logic                done_now;
  logic [MaxWidth-1:0] shifted;

  always_comb begin
    code_lit   = (code_q < MaxWidth'(Literals));
    known      = ({1'b0, code_q} < ne_q);
    table_open = (ne_q < (NeW'(1) << MaxWidth));
    clen       = code_lit ? LenW'(1) : rd_len;
    cfirst     = code_lit ? code_q[7:0] : rd_first;
    plen       = prev_len_q + LenW'(1);
    plen_clamp = (plen > LenW'(MaxString + 1)) ? LenW'(MaxString + 1) : plen;
    len_full   = known ? clen : plen;
    ne_new     = ne_q + NeW'(table_open);
    grow_at    = (NeW'(1) << cw_q) - NeW'(1);
    bytes_inc  = {1'b0, bytes_q} + 33'd1;
    done_now   = (bytes_inc >= {1'b0, total_q});
    stop       = halted_q || (bytes_q >= total_q);
    shifted    = {gather_q[MaxWidth-2:0], byte_q[7]};
  end

  // Next state and datapath control.
  always_comb begin
    state_d      = state_q;
    bytes_d      = bytes_q;
    byte_d       = byte_q;
    bits_d       = bits_q;
    gather_d     = gather_q;
    held_d       = held_q;
    cw_d         = cw_q;
    ne_d         = ne_q;
    prev_d       = prev_q;
    prev_len_d   = prev_len_q;
    prev_first_d = prev_first_q;
    first_seen_d = first_seen_q;
    halted_d     = halted_q;
    code_d       = code_q;
    c_d          = c_q;
    len_d        = len_q;
    i_d          = i_q;
    pos_d        = pos_q;
    dict_we      = 1'b0;
    dict_wa      = ne_q[MaxWidth-1:0];
    dict_wp      = prev_q;
    dict_ws      = known ? cfirst : prev_first_q;
    dict_wf      = prev_first_q;
    dict_wl      = plen_clamp;
    dict_ra      = code_q;
    stk_we       = 1'b0;
    stk_wa       = '0;
    stk_wd       = '0;
    stk_ra       = i_q[AW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid && !stop) begin
          byte_d  = in_i.in_byte;
          bits_d  = 4'd8;
          state_d = ST_BITS;
        end
      end

      // One stream bit per cycle into the code gatherer.
      ST_BITS: begin
        byte_d = {byte_q[6:0], 1'b0};
        bits_d = bits_q - 4'd1;
        if (held_q + CwW'(1) >= cw_q) begin
          code_d   = shifted;
          dict_ra  = shifted;
          gather_d = '0;
          held_d   = '0;
          state_d  = ST_LOOK;
        end else begin
          gather_d = shifted;
          held_d   = held_q + CwW'(1);
          if (bits_q == 4'd1) begin
            state_d = ST_IDLE;
          end
        end
      end

      // Dictionary data is here: decide, add an entry if room, start the walk.
      ST_LOOK: begin
        i_d = '0;
        if (!first_seen_q) begin
          first_seen_d = 1'b1;
          prev_d       = MaxWidth'(code_q[7:0]);
          prev_len_d   = LenW'(1);
          prev_first_d = code_q[7:0];
          stk_we       = 1'b1;
          stk_wa       = '0;
          stk_wd       = code_q[7:0];
          len_d        = PW'(1);
          state_d      = ST_EMIT_RD;
        end else if (len_full > LenW'(MaxString)) begin
          halted_d = 1'b1;
          state_d  = ST_ERR_OUT;
        end else begin
          len_d = PW'(len_full);
          if (known) begin
            c_d     = code_q;
            pos_d   = PW'(len_full);
            dict_ra = code_q;
          end else begin
            c_d     = prev_q;
            pos_d   = PW'(len_full - LenW'(1));
            dict_ra = prev_q;
            stk_we  = 1'b1;
            stk_wa  = AW'(len_full - LenW'(1));
            stk_wd  = prev_first_q;
          end
          if (table_open) begin
            dict_we = 1'b1;
            ne_d    = ne_new;
            if (known) begin
              prev_d       = code_q;
              prev_len_d   = clen;
              prev_first_d = cfirst;
            end else begin
              prev_d     = ne_q[MaxWidth-1:0];
              prev_len_d = plen_clamp;
            end
          end else if (known) begin
            prev_d       = code_q;
            prev_len_d   = clen;
            prev_first_d = cfirst;
          end
          if (cw_q < CwW'(MaxWidth) && ne_new >= grow_at) begin
            cw_d = cw_q + CwW'(1);
          end
          state_d = ST_SPELL;
        end
      end

      // Walk the prefix chain, one entry per cycle.
      ST_SPELL: begin
        if (c_q >= MaxWidth'(Literals) && pos_q > PW'(1)) begin
          stk_we  = 1'b1;
          stk_wa  = AW'(pos_q - PW'(1));
          stk_wd  = rd_suffix;
          pos_d   = pos_q - PW'(1);
          c_d     = rd_prefix;
          dict_ra = rd_prefix;
        end else begin
          if (pos_q != '0) begin
            stk_we = 1'b1;
            stk_wa = AW'(pos_q - PW'(1));
            stk_wd = c_q[7:0];
          end
          state_d = ST_EMIT_RD;
        end
      end

      ST_EMIT_RD: begin
        if (i_q < len_q && bytes_q < total_q) begin
          state_d = ST_EMIT_OUT;
        end else if (stop || bits_q == 4'd0) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_BITS;
        end
      end

      ST_EMIT_OUT: begin
        if (out_o.ready) begin
          bytes_d = bytes_inc[31:0];
          i_d     = i_q + PW'(1);
          state_d = ST_EMIT_RD;
        end
      end

      ST_ERR_OUT: begin
        if (out_o.ready) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      total_q      <= '0;
      bytes_q      <= '0;
      bits_q       <= '0;
      gather_q     <= '0;
      held_q       <= '0;
      cw_q         <= CwW'(StartWidth);
      ne_q         <= NeW'(Literals);
      prev_q       <= '0;
      prev_len_q   <= LenW'(1);
      prev_first_q <= '0;
      first_seen_q <= 1'b0;
      halted_q     <= 1'b0;
      len_q        <= '0;
      i_q          <= '0;
      pos_q        <= '0;
    end else begin
      state_q      <= state_d;
      if (cfg_i.valid) begin
        total_q <= cfg_i.total_bytes;
      end
      bytes_q      <= bytes_d;
      bits_q       <= bits_d;
      gather_q     <= gather_d;
      held_q       <= held_d;
      cw_q         <= cw_d;
      ne_q         <= ne_d;
      prev_q       <= prev_d;
      prev_len_q   <= prev_len_d;
      prev_first_q <= prev_first_d;
      first_seen_q <= first_seen_d;
      halted_q     <= halted_d;
      len_q        <= len_d;
      i_q          <= i_d;
      pos_q        <= pos_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    code_q <= code_d;
    c_q    <= c_d;
  end

  // Channel outputs.
  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = (state_q == ST_EMIT_OUT) || (state_q == ST_ERR_OUT);
  assign out_o.out_byte = (state_q == ST_ERR_OUT) ? 8'd0 : stk_rd_q;
  assign out_o.last_of_run = (state_q == ST_ERR_OUT) || (i_q + PW'(1) == len_q) || done_now;
  assign out_o.finished = (state_q == ST_EMIT_OUT) && done_now;
  assign out_o.string_too_long = (state_q == ST_ERR_OUT);

  // Checks on the decoder's own logic.
  a_width_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cw_q <= CwW'(MaxWidth)) else $error("code width beyond limit");
  a_table_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ne_q <= (NeW'(1) << MaxWidth)) else $error("next entry beyond table");
  a_no_emit_past_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT_OUT) |-> (bytes_q < total_q)) else $error("emit past total");
  a_halt_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q) else $error("halt cleared");

endmodule

`default_nettype wire
